FILE: rtl/stall_occupancy_detector_assert.svh
// Assertion macros shared by the stall occupancy checker.
`ifndef STALL_OCCUPANCY_DETECTOR_ASSERT_SVH
`define STALL_OCCUPANCY_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SOD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stall occupancy check failed");

// Next-cycle implication, disabled during reset.
`define SOD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stall occupancy check failed");

`endif

FILE: rtl/sod_pkg.sv
// Shared types, constants and arithmetic helpers of the stall occupancy detector.
package sod_pkg;

  localparam int STALLS_DEF      = 4;
  localparam int ROUNDS_DEF      = 5;

  localparam int SAMPLE_W        = 10;
  localparam int SCALED_W        = 8;
  localparam int WIN_W           = 4;
  localparam int IDX_OUT_W       = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 8;

  localparam logic [SCALED_W-1:0] SCALED_MAX   = 8'd255;
  localparam logic [9:0]          SAMPLE_MAX   = 10'd1023;
  localparam logic [SCALED_W-1:0] DEFAULT_SENS = 8'd5;

  localparam logic [7:0] THR_RST   = 8'd19;
  localparam logic [3:0] WARM_RST  = 4'd10;
  localparam logic [7:0] FLOOR_RST = 8'd1;
  localparam logic [7:0] CEIL_RST  = 8'd10;

  // Divide by five through a reciprocal, exact for all 8-bit values.
  localparam int CAL_DIVISOR = 5;
  localparam int CAL_SHIFT   = SCALED_W + $clog2(CAL_DIVISOR);
  localparam int CAL_MULT    = (2**CAL_SHIFT + CAL_DIVISOR - 1) / CAL_DIVISOR;
  localparam int CAL_MULT_W  = CAL_SHIFT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OCC_THR  = 2'd0,
    REG_WARMUP   = 2'd1,
    REG_SENS_MIN = 2'd2,
    REG_SENS_MAX = 2'd3
  } sod_reg_t;

  typedef struct packed {
    logic [7:0] thr;
    logic [3:0] warmup;
    logic [7:0] sens_min;
    logic [7:0] sens_max;
  } sod_cfg_t;

  // Per-stall state apart from the running sum.
  typedef struct packed {
    logic [SCALED_W-1:0] prev;
    logic [SCALED_W-1:0] sens;
    logic                occ;
    logic                last_rdy;
    logic                chg;
  } sod_stall_t;

  // sample * 255 / 1023, rounded down.
  function automatic logic [SCALED_W-1:0] sod_scale(input logic [SAMPLE_W-1:0] s);
    logic [17:0] x;
    logic [7:0]  q0;
    logic [10:0] r;
    x  = {s, 8'b0} - {8'b0, s};
    q0 = x[17:10];
    r  = {1'b0, x[9:0]} + {3'b0, q0};
    sod_scale = (r >= {1'b0, SAMPLE_MAX}) ? q0 + 8'd1 : q0;
  endfunction

  // Sensitivity from the previous average: prev / 5, floor first, then ceiling.
  function automatic logic [SCALED_W-1:0] sod_calib(input logic [SCALED_W-1:0] prev,
                                                    input logic [7:0] lo,
                                                    input logic [7:0] hi);
    logic [SCALED_W+CAL_MULT_W-1:0] p;
    logic [SCALED_W-1:0]            v;
    p = {{CAL_MULT_W{1'b0}}, prev} * (SCALED_W+CAL_MULT_W)'(CAL_MULT);
    v = SCALED_W'(p >> CAL_SHIFT);
    if (v < lo) begin
      sod_calib = lo;
    end else if (v > hi) begin
      sod_calib = hi;
    end else begin
      sod_calib = v;
    end
  endfunction

endpackage

FILE: rtl/sod_cell.sv
// One stall cell of the state ring: holds a stall's state and passes it on.
module sod_cell
  import sod_pkg::*;
#(
  parameter int SUM_W = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  sod_stall_t       d_state,
  input  logic [SUM_W-1:0] d_sum,
  output sod_stall_t       q_state,
  output logic [SUM_W-1:0] q_sum
);

  sod_stall_t       state_r;
  logic [SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev     <= '0;
      state_r.sens     <= DEFAULT_SENS;
      state_r.occ      <= 1'b0;
      state_r.last_rdy <= 1'b0;
      state_r.chg      <= 1'b0;
      sum_r            <= '0;
    end else if (shift) begin
      state_r <= d_state;
      sum_r   <= d_sum;
    end
  end

  assign q_state = state_r;
  assign q_sum   = sum_r;

endmodule

FILE: rtl/sod_proc.sv
// Head-of-ring update: accumulate a sample or close the window for one stall.
module sod_proc
  import sod_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF,
  parameter int SUM_W  = 11
) (
  input  logic                close,
  input  logic                win_ready,
  input  logic [SAMPLE_W-1:0] sample,
  input  sod_cfg_t            cfg,
  input  sod_stall_t          head,
  input  logic [SUM_W-1:0]    head_sum,
  output sod_stall_t          nxt,
  output logic [SUM_W-1:0]    nxt_sum
);

  // Exact sum / ROUNDS by a rounded-up reciprocal.
  localparam int SH       = SUM_W + $clog2(ROUNDS);
  localparam int MULT     = (2**SH + ROUNDS - 1) / ROUNDS;
  localparam int MULT_W   = SH + 1;
  localparam int PROD_W   = SUM_W + MULT_W;
  localparam int AVG_F_W  = PROD_W - SH;

  logic [PROD_W-1:0]   prod;
  logic [AVG_F_W-1:0]  avg_full;
  logic [SCALED_W-1:0] cur;
  logic [SCALED_W:0]   cur_e;
  logic [SCALED_W:0]   prev_plus;
  logic [SCALED_W:0]   cur_plus;
  logic [SCALED_W-1:0] cal;
  logic                occ_new;

  assign prod      = {{MULT_W{1'b0}}, head_sum} * PROD_W'(MULT);
  assign avg_full  = AVG_F_W'(prod >> SH);
  assign cur       = (avg_full > AVG_F_W'(SCALED_MAX)) ? SCALED_MAX : SCALED_W'(avg_full);
  assign cur_e     = {1'b0, cur};
  assign prev_plus = {1'b0, head.prev} + {1'b0, head.sens};
  assign cur_plus  = {1'b0, cur} + {1'b0, head.sens};
  assign cal       = sod_calib(head.prev, cfg.sens_min, cfg.sens_max);

  always_comb begin
    nxt     = head;
    nxt_sum = head_sum + SUM_W'(sod_scale(sample));
    occ_new = 1'b0;
    if (close) begin
      nxt_sum  = '0;
      nxt.prev = cur;
      if (!win_ready) begin
        occ_new = cur < cfg.thr;
        nxt.occ = occ_new;
        if (!occ_new) begin
          nxt.sens = cal;
        end
      end else begin
        // Hysteresis on the change against the previous window.
        if (head.occ) begin
          occ_new = !(cur_e > prev_plus);
        end else begin
          occ_new = {1'b0, head.prev} > cur_plus;
        end
        nxt.occ      = occ_new;
        nxt.chg      = occ_new != head.last_rdy;
        nxt.last_rdy = occ_new;
        if ((occ_new != head.last_rdy) && !occ_new) begin
          nxt.sens = cal;
        end
      end
    end
  end

endmodule

FILE: rtl/stall_occupancy_detector.sv
// Stall occupancy detector top level: ring of stall cells, window control, result register.
//
//   channel | direction | payload                                   | handshake
//   in_     | input     | in_sample                                 | in_valid / in_ready
//   out_    | output    | stall_index, occupied, changed, average,  | out_valid / out_ready
//           |           | sensitivity, ready_res, last              |
//   cfg_    | input     | cfg_index, cfg_data                       | cfg_valid / cfg_ready
//
// The ring of stall cells rotates by one per sample taken.
// At the end of each window the ring walks all STALLS cells, one step and one result per
// cycle while the output register is empty or out_ready is high; in_ready is low meanwhile.
// Synchronous active-low reset; no clearing pass, the block accepts right after reset.
// A stalled result holds in the output register; only the walk waits for it.
module stall_occupancy_detector
  import sod_pkg::*;
#(
  parameter int STALLS            = STALLS_DEF,
  parameter int ROUNDS_PER_WINDOW = ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_OUT_W-1:0]  out_stall_index,
  output logic                  out_occupied,
  output logic                  out_changed,
  output logic [SCALED_W-1:0]   out_average,
  output logic [SCALED_W-1:0]   out_sensitivity,
  output logic                  out_ready_res,
  output logic                  out_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PTR_W = (STALLS > 1) ? $clog2(STALLS) : 1;
  localparam int RND_W = (ROUNDS_PER_WINDOW > 1) ? $clog2(ROUNDS_PER_WINDOW) : 1;
  localparam int SUM_W = $clog2(ROUNDS_PER_WINDOW * 255 + 1);

  typedef enum logic {ST_ACC, ST_EMIT} state_t;

  state_t              state_r;
  logic [PTR_W-1:0]    ptr_r;
  logic [RND_W-1:0]    rnd_r;
  logic [PTR_W-1:0]    emit_r;
  logic [WIN_W-1:0]    win_r;
  sod_cfg_t            cfg_r;

  logic                out_valid_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic                out_occ_r;
  logic                out_chg_r;
  logic [SCALED_W-1:0] out_avg_r;
  logic [SCALED_W-1:0] out_sens_r;
  logic                out_rdy_r;
  logic                out_last_r;

  sod_stall_t          cell_q [STALLS];
  logic [SUM_W-1:0]    sum_q  [STALLS];
  sod_stall_t          head_nxt;
  logic [SUM_W-1:0]    head_sum_nxt;

  logic in_acc;
  logic emit_step;
  logic shift;
  logic win_ready;
  logic emit_last;

  assign in_ready  = (state_r == ST_ACC);
  assign in_acc    = in_valid && in_ready;
  assign emit_step = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign shift     = in_acc || emit_step;
  assign win_ready = win_r >= cfg_r.warmup;
  assign emit_last = emit_r == PTR_W'(STALLS - 1);
  assign cfg_ready = 1'b1;

  sod_proc #(
    .ROUNDS (ROUNDS_PER_WINDOW),
    .SUM_W  (SUM_W)
  ) u_proc (
    .close     (state_r == ST_EMIT),
    .win_ready (win_ready),
    .sample    (in_sample),
    .cfg       (cfg_r),
    .head      (cell_q[0]),
    .head_sum  (sum_q[0]),
    .nxt       (head_nxt),
    .nxt_sum   (head_sum_nxt)
  );

  // Ring: each cell takes its upper neighbor, the tail takes the updated head.
  for (genvar i = 0; i < STALLS; i++) begin : g_cell
    if (i == STALLS - 1) begin : g_tail
      sod_cell #(.SUM_W(SUM_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .d_state (head_nxt),
        .d_sum   (head_sum_nxt),
        .q_state (cell_q[i]),
        .q_sum   (sum_q[i])
      );
    end else begin : g_mid
      sod_cell #(.SUM_W(SUM_W)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (shift),
        .d_state (cell_q[i+1]),
        .d_sum   (sum_q[i+1]),
        .q_state (cell_q[i]),
        .q_sum   (sum_q[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr      <= THR_RST;
      cfg_r.warmup   <= WARM_RST;
      cfg_r.sens_min <= FLOOR_RST;
      cfg_r.sens_max <= CEIL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (sod_reg_t'(cfg_index))
        REG_OCC_THR:  cfg_r.thr      <= cfg_data;
        REG_WARMUP:   cfg_r.warmup   <= cfg_data[WIN_W-1:0];
        REG_SENS_MIN: cfg_r.sens_min <= cfg_data;
        REG_SENS_MAX: cfg_r.sens_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      ptr_r       <= '0;
      rnd_r       <= '0;
      emit_r      <= '0;
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready && !emit_step) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_ACC: begin
          if (in_acc) begin
            if (ptr_r == PTR_W'(STALLS - 1)) begin
              ptr_r <= '0;
              if (rnd_r == RND_W'(ROUNDS_PER_WINDOW - 1)) begin
                rnd_r   <= '0;
                emit_r  <= '0;
                state_r <= ST_EMIT;
              end else begin
                rnd_r <= rnd_r + 1'b1;
              end
            end else begin
              ptr_r <= ptr_r + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (emit_step) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= IDX_OUT_W'(emit_r);
            out_occ_r   <= head_nxt.occ;
            out_chg_r   <= head_nxt.chg;
            out_avg_r   <= head_nxt.prev;
            out_sens_r  <= head_nxt.sens;
            out_rdy_r   <= win_ready;
            out_last_r  <= emit_last;
            if (emit_last) begin
              state_r <= ST_ACC;
              if (!win_ready) begin
                win_r <= win_r + 1'b1;
              end
            end else begin
              emit_r <= emit_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stall_index = out_idx_r;
  assign out_occupied    = out_occ_r;
  assign out_changed     = out_chg_r;
  assign out_average     = out_avg_r;
  assign out_sensitivity = out_sens_r;
  assign out_ready_res   = out_rdy_r;
  assign out_last        = out_last_r;

endmodule

FILE: rtl/sod_checker.sv
// Port-level checker for the stall occupancy detector, bound to the top level.
`include "stall_occupancy_detector_assert.svh"

module sod_checker
  import sod_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [IDX_OUT_W-1:0] out_stall_index,
  input logic [SCALED_W-1:0]  out_average,
  input logic                 out_last
);

  // A stalled word holds.
  `SOD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_average) && $stable(out_stall_index))

  // No sample is taken until the window's last result is out.
  `SOD_ASSERT_NOW(a_no_in_mid_window, clk, rst_n, out_valid && !out_last, !in_ready)

  // The next result of a window follows at once.
  `SOD_ASSERT_NEXT(a_walk_continues, clk, rst_n, out_valid && out_ready && !out_last,
    out_valid)

  // Results of a window come in stall order.
  `SOD_ASSERT_NEXT(a_index_advances, clk, rst_n, out_valid && out_ready && !out_last,
    out_stall_index == $past(out_stall_index) + 2'd1)

endmodule

bind stall_occupancy_detector sod_checker u_sod_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_stall_index (out_stall_index),
  .out_average     (out_average),
  .out_last        (out_last)
);
